// ===== rtl/pid_filtered_derivative_antiwindup_assert.svh =====
// ----------------------------------------------------------------------------
// pid filtered derivative anti-windup assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef PID_FILTERED_DERIVATIVE_ANTIWINDUP_ASSERT_SVH
`define PID_FILTERED_DERIVATIVE_ANTIWINDUP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked on every edge outside reset
`define PFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define PFD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFD_ASSERT_RST(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// shared types and constants of the filtered-derivative pid controller
// ----------------------------------------------------------------------------
package pfd_pkg;

    // widths
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 17;
    localparam int DATA_W   = 32;
    localparam int DRIVE_W  = 15;
    localparam int CLAMP_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int FRAC_W   = 16;
    localparam int TERM_W   = PROD_W + 1 - FRAC_W;
    localparam int SUM_W    = TERM_W + 3;

    // band limits, 0..100 in q8.8
    localparam logic signed [DATA_W-1:0] BAND_TOP  = 32'sd25600;
    localparam logic [DRIVE_W-1:0]       DRIVE_TOP = 15'd25600;
    localparam logic [DRIVE_W-1:0]       DRIVE_BOT = 15'd0;

    // clamp flag codes
    localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
    localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAST_OUT1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_OUT2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERR0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERR1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERR2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDUP    = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] sensor;
    } pfd_in_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [CLAMP_W-1:0] clamp_state;
    } pfd_out_t;

    // q16.16 coefficient set
    typedef struct packed {
        logic signed [DATA_W-1:0] past_out1_coef;
        logic signed [DATA_W-1:0] past_out2_coef;
        logic signed [DATA_W-1:0] err0_coef;
        logic signed [DATA_W-1:0] err1_coef;
        logic signed [DATA_W-1:0] err2_coef;
        logic signed [DATA_W-1:0] windup_gain;
    } pfd_coef_t;

endpackage

// ===== rtl/pfd_term.sv =====
// ----------------------------------------------------------------------------
// pfd_term
// one coefficient times sample product, rounded half up from q.24 to q8.8
// ----------------------------------------------------------------------------
module pfd_term (
    input  logic signed [pfd_pkg::DATA_W-1:0] coef,
    input  logic signed [pfd_pkg::DATA_W-1:0] sample,
    output logic signed [pfd_pkg::TERM_W-1:0] term
);

    logic signed [pfd_pkg::PROD_W-1:0] prod;
    logic signed [pfd_pkg::PROD_W:0]   rounded;

    assign prod    = coef * sample;
    // add half an lsb, then arithmetic drop of the fraction
    assign rounded = {prod[pfd_pkg::PROD_W-1], prod} + 65'sd32768;
    assign term    = rounded[pfd_pkg::PROD_W:pfd_pkg::FRAC_W];

endmodule

// ===== rtl/pfd_core.sv =====
// ----------------------------------------------------------------------------
// pfd_core
// difference equation, saturation, band clamp and controller history
// ----------------------------------------------------------------------------
`include "pid_filtered_derivative_antiwindup_assert.svh"

module pfd_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic signed [pfd_pkg::ERR_W-1:0]  err0,
    input  pfd_pkg::pfd_coef_t                coef,
    output pfd_pkg::pfd_out_t                 result
);

    logic signed [pfd_pkg::ERR_W-1:0]  prev_err_reg;
    logic signed [pfd_pkg::ERR_W-1:0]  older_err_reg;
    logic signed [pfd_pkg::DATA_W-1:0] prev_raw_reg;
    logic signed [pfd_pkg::DATA_W-1:0] older_raw_reg;
    logic signed [pfd_pkg::DATA_W-1:0] overshoot_reg;
    logic signed [pfd_pkg::DATA_W-1:0] overshoot_next;

    logic signed [pfd_pkg::TERM_W-1:0] t_out1, t_out2, t_err0, t_err1, t_err2, t_wind;
    logic signed [pfd_pkg::SUM_W-1:0]  sum;
    logic signed [pfd_pkg::DATA_W-1:0] raw;
    logic signed [pfd_pkg::DATA_W:0]   neg_raw;
    logic signed [pfd_pkg::DATA_W:0]   over_top;
    logic                              fits;

    pfd_term u_out1 (.coef(coef.past_out1_coef), .sample(prev_raw_reg),  .term(t_out1));
    pfd_term u_out2 (.coef(coef.past_out2_coef), .sample(older_raw_reg), .term(t_out2));
    pfd_term u_err0 (.coef(coef.err0_coef), .sample(32'(err0)),          .term(t_err0));
    pfd_term u_err1 (.coef(coef.err1_coef), .sample(32'(prev_err_reg)),  .term(t_err1));
    pfd_term u_err2 (.coef(coef.err2_coef), .sample(32'(older_err_reg)), .term(t_err2));
    pfd_term u_wind (.coef(coef.windup_gain), .sample(overshoot_reg),    .term(t_wind));

    always_comb begin
        sum = -pfd_pkg::SUM_W'(t_out1) - pfd_pkg::SUM_W'(t_out2)
              + pfd_pkg::SUM_W'(t_err0) + pfd_pkg::SUM_W'(t_err1)
              + pfd_pkg::SUM_W'(t_err2) + pfd_pkg::SUM_W'(t_wind);
        // fits when every bit above the sign position matches it
        fits = (sum[pfd_pkg::SUM_W-1:pfd_pkg::DATA_W-1] == '0)
            || (sum[pfd_pkg::SUM_W-1:pfd_pkg::DATA_W-1] == '1);
        if (fits) begin
            raw = sum[pfd_pkg::DATA_W-1:0];
        end else if (sum[pfd_pkg::SUM_W-1]) begin
            raw = {1'b1, {(pfd_pkg::DATA_W-1){1'b0}}};
        end else begin
            raw = {1'b0, {(pfd_pkg::DATA_W-1){1'b1}}};
        end

        neg_raw  = -{raw[pfd_pkg::DATA_W-1], raw};
        over_top = {pfd_pkg::BAND_TOP[pfd_pkg::DATA_W-1], pfd_pkg::BAND_TOP}
                   - {raw[pfd_pkg::DATA_W-1], raw};

        if (raw > pfd_pkg::BAND_TOP) begin
            overshoot_next     = over_top[pfd_pkg::DATA_W-1:0];
            result.drive       = pfd_pkg::DRIVE_TOP;
            result.clamp_state = pfd_pkg::CLAMP_HIGH;
        end else if (raw[pfd_pkg::DATA_W-1]) begin
            // most negative raw has no positive twin
            if (neg_raw[pfd_pkg::DATA_W] != neg_raw[pfd_pkg::DATA_W-1]) begin
                overshoot_next = {1'b0, {(pfd_pkg::DATA_W-1){1'b1}}};
            end else begin
                overshoot_next = neg_raw[pfd_pkg::DATA_W-1:0];
            end
            result.drive       = pfd_pkg::DRIVE_BOT;
            result.clamp_state = pfd_pkg::CLAMP_LOW;
        end else begin
            overshoot_next     = '0;
            result.drive       = raw[pfd_pkg::DRIVE_W-1:0];
            result.clamp_state = pfd_pkg::CLAMP_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg  <= '0;
            older_err_reg <= '0;
            prev_raw_reg  <= '0;
            older_raw_reg <= '0;
            overshoot_reg <= '0;
        end else if (advance) begin
            older_err_reg <= prev_err_reg;
            prev_err_reg  <= err0;
            older_raw_reg <= prev_raw_reg;
            prev_raw_reg  <= raw;
            overshoot_reg <= overshoot_next;
        end
    end

    `PFD_ASSERT(a_over_high, aclk, aresetn, (prev_raw_reg > pfd_pkg::BAND_TOP) == (overshoot_reg < 0), "overshoot sign disagrees with high clamp")
    `PFD_ASSERT(a_over_low, aclk, aresetn, (prev_raw_reg < 0) == (overshoot_reg > 0), "overshoot sign disagrees with low clamp")
    `PFD_ASSERT(a_over_exact, aclk, aresetn, overshoot_reg < 0 |-> prev_raw_reg == pfd_pkg::BAND_TOP - overshoot_reg, "high overshoot does not match raw output")

endmodule

// ===== rtl/pid_filtered_derivative_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_filtered_derivative_antiwindup
// discrete pid with filtered derivative and back-calculation anti-windup
// ----------------------------------------------------------------------------
// each item carries a q8.8 setpoint and sensor sample and yields one item with
// the drive clamped to 0..100 (q8.8) and a clamp flag. the block takes one item
// per clock while the output is not stalled: the error is registered on accept,
// and once the item advances, six q16.16 by 32-bit products, their sum and the
// band clamp are evaluated and land in the output register together with the
// updated history. each item needs the raw output of the one before. the user
// must load the coefficient registers through the write port only while no
// item is in flight; the block itself does not enforce it. they reset to zero.
`include "pid_filtered_derivative_antiwindup_assert.svh"

module pid_filtered_derivative_antiwindup (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pfd_pkg::pfd_in_t                    s_payload,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output pfd_pkg::pfd_out_t                   m_payload,
    // coefficient writes
    input  logic                                cfg_wr_en,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfd_pkg::DATA_W-1:0]          cfg_wdata
);

    // input stage holds the error of one item
    logic                              in_valid_reg;
    logic signed [pfd_pkg::ERR_W-1:0]  err_reg;
    logic signed [pfd_pkg::ERR_W-1:0]  err_next;

    // output stage
    logic                              out_valid_reg;
    pfd_pkg::pfd_out_t                 out_reg;
    pfd_pkg::pfd_out_t                 core_result;

    pfd_pkg::pfd_coef_t                coef_reg;

    logic                              advance;
    logic                              s_take;

    // an item moves forward when the output slot is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    // setpoint minus sensor always fits 17 bits
    assign err_next = {s_payload.setpoint[pfd_pkg::SAMPLE_W-1], s_payload.setpoint}
                    - {s_payload.sensor[pfd_pkg::SAMPLE_W-1], s_payload.sensor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            err_reg <= err_next;
        end
    end

    pfd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .err0    (err_reg),
        .coef    (coef_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // register file, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pfd_pkg::REG_PAST_OUT1: coef_reg.past_out1_coef <= cfg_wdata;
                pfd_pkg::REG_PAST_OUT2: coef_reg.past_out2_coef <= cfg_wdata;
                pfd_pkg::REG_ERR0:      coef_reg.err0_coef      <= cfg_wdata;
                pfd_pkg::REG_ERR1:      coef_reg.err1_coef      <= cfg_wdata;
                pfd_pkg::REG_ERR2:      coef_reg.err2_coef      <= cfg_wdata;
                pfd_pkg::REG_WINDUP:    coef_reg.windup_gain    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    `PFD_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !in_valid_reg && !out_valid_reg, "pipeline not empty after reset")
    `PFD_ASSERT(a_high_drive, aclk, aresetn, m_valid && m_payload.clamp_state == pfd_pkg::CLAMP_HIGH |-> m_payload.drive == pfd_pkg::DRIVE_TOP, "high clamp without full drive")
    `PFD_ASSERT(a_low_drive, aclk, aresetn, m_valid && m_payload.clamp_state == pfd_pkg::CLAMP_LOW |-> m_payload.drive == pfd_pkg::DRIVE_BOT, "low clamp without zero drive")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the filtered-derivative pid with anti-windup: a
// cycle-free predictor tracks the error and raw-output history, every
// accepted result item is compared field by field, under directed, random,
// backpressure and pause traffic over several coefficient sets
// ----------------------------------------------------------------------------
module tb_top;
    import pfd_pkg::*;

    // timing of the run
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving
    localparam int SET_ITEMS    = 200;   // random items per coefficient set

    // write indexes outside the register map
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    // kinds of random coefficient sets
    localparam int COEF_TUNED      = 0;
    localparam int COEF_RAW        = 1;
    localparam int COEF_EXTREME    = 2;
    localparam int COEF_INTEGRATOR = 3;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // block inputs start at known values
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    pfd_in_t                s_payload = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    pfd_out_t               m_payload;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]      cfg_wdata = '0;

    pid_filtered_derivative_antiwindup dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // traffic shaping, percent of cycles spent idle on each side
    int src_idle_pct  = 35;
    int sink_idle_pct = 71;
    int hold_len      = 0;

    int fail_count  = 0;
    int stall_count = 0;

    // predictor copy of the coefficients and the controller history
    pfd_coef_t coef = '0;
    int hist_err1 = 0;   // error one step back
    int hist_err2 = 0;   // error two steps back
    int hist_raw1 = 0;   // raw output one step back
    int hist_raw2 = 0;   // raw output two steps back
    int hist_over = 0;   // overshoot beyond the band

    // expected result items, oldest first
    pfd_out_t pending_drive[$];

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // q16.16 times q8.8, rounded half up back to q8.8
    function automatic longint scaled_term(int c, int s);
        longint p;
        p = longint'(c) * longint'(s) + 64'sd32768;
        return p >>> 16;
    endfunction

    // saturate to a signed 32-bit word
    function automatic int clip_word(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic pfd_out_t predict_drive(pfd_in_t item);
        int       err_now;
        longint   acc;
        int       raw;
        pfd_out_t res;
        err_now = int'($signed(item.setpoint)) - int'($signed(item.sensor));
        // difference equation: past outputs subtracted, errors and windup added
        acc = - scaled_term(coef.past_out1_coef, hist_raw1)
              - scaled_term(coef.past_out2_coef, hist_raw2)
              + scaled_term(coef.err0_coef, err_now)
              + scaled_term(coef.err1_coef, hist_err1)
              + scaled_term(coef.err2_coef, hist_err2)
              + scaled_term(coef.windup_gain, hist_over);
        raw = clip_word(acc);
        if (raw > int'(BAND_TOP)) begin
            hist_over       = clip_word(longint'(BAND_TOP) - longint'(raw));
            res.drive       = DRIVE_TOP;
            res.clamp_state = CLAMP_HIGH;
        end else if (raw < 0) begin
            // -raw of the most negative word saturates
            hist_over       = clip_word(-longint'(raw));
            res.drive       = DRIVE_BOT;
            res.clamp_state = CLAMP_LOW;
        end else begin
            hist_over       = 0;
            res.drive       = raw[DRIVE_W-1:0];
            res.clamp_state = CLAMP_NONE;
        end
        hist_err2 = hist_err1;
        hist_err1 = err_now;
        hist_raw2 = hist_raw1;
        hist_raw1 = raw;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result check and prediction, both sampled at the edge that accepts
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        pfd_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_drive.size() == 0) begin
                    $error("unexpected result item: drive %0d clamp_state %0d",
                           m_payload.drive, m_payload.clamp_state);
                    fail_count++;
                end else begin
                    want = pending_drive.pop_front();
                    if (m_payload.drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, m_payload.drive);
                        fail_count++;
                    end
                    if (m_payload.clamp_state !== want.clamp_state) begin
                        $error("clamp_state: expected %0d, got %0d",
                               want.clamp_state, m_payload.clamp_state);
                        fail_count++;
                    end
                end
            end
            // the item accepted now gets its expectation after any pop
            if (s_valid && s_ready)
                pending_drive.push_back(predict_drive(s_payload));
        end
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_len > 0) begin
            m_ready  <= 1'b0;
            hold_len <= hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // watchdog on cycles where no item moves on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    function automatic pfd_in_t make_item(int sp, int sn);
        pfd_in_t item;
        item.setpoint = sp[SAMPLE_W-1:0];
        item.sensor   = sn[SAMPLE_W-1:0];
        return item;
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return 25600;
        endcase
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(5))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return 65536;
        endcase
    endfunction

    // near the band where the loop settles, full-range noise, corner samples and steps
    function automatic pfd_in_t random_item();
        int sp;
        case ($urandom_range(9))
            0, 1, 2, 3: return make_item($urandom, $urandom);
            4, 5, 6, 7: begin
                sp = span(-512, 26112);
                return make_item(sp, sp + span(-768, 768));
            end
            8:          return make_item(pick_sample(), pick_sample());
            default: begin
                // setpoint step with the sensor at rest
                sp = span(0, 25600);
                return make_item(sp, 0);
            end
        endcase
    endfunction

    function automatic pfd_coef_t random_coefs(int kind);
        pfd_coef_t c;
        case (kind)
            COEF_TUNED: begin
                c.past_out1_coef = -span(65536, 131072);
                c.past_out2_coef = span(0, 65536);
                c.err0_coef      = span(-262144, 262144);
                c.err1_coef      = span(-262144, 262144);
                c.err2_coef      = span(-262144, 262144);
                c.windup_gain    = span(-65536, 65536);
            end
            COEF_RAW: begin
                c.past_out1_coef = $urandom;
                c.past_out2_coef = $urandom;
                c.err0_coef      = $urandom;
                c.err1_coef      = $urandom;
                c.err2_coef      = $urandom;
                c.windup_gain    = $urandom;
            end
            COEF_EXTREME: begin
                c.past_out1_coef = pick_extreme();
                c.past_out2_coef = pick_extreme();
                c.err0_coef      = pick_extreme();
                c.err1_coef      = pick_extreme();
                c.err2_coef      = pick_extreme();
                c.windup_gain    = pick_extreme();
            end
            default: begin
                // pure integrator on the previous raw output
                c.past_out1_coef = -65536;
                c.past_out2_coef = 0;
                c.err0_coef      = span(0, 131072);
                c.err1_coef      = -c.err0_coef + span(-8192, 8192);
                c.err2_coef      = span(-4096, 4096);
                c.windup_gain    = span(0, 65536);
            end
        endcase
        return c;
    endfunction

    // offer one item, with random gaps before it, and wait for its accept
    task automatic send_item(input pfd_in_t item);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // stop offering, then wait until every expected item has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_drive.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register write, leaves the write enable high for a following one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_PAST_OUT1: coef.past_out1_coef = data;
            REG_PAST_OUT2: coef.past_out2_coef = data;
            REG_ERR0:      coef.err0_coef      = data;
            REG_ERR1:      coef.err1_coef      = data;
            REG_ERR2:      coef.err2_coef      = data;
            REG_WINDUP:    coef.windup_gain    = data;
            default: ;     // unmapped index, block ignores it
        endcase
    endtask

    // full coefficient set, only while the block is idle
    task automatic load_coefs(input pfd_coef_t c);
        write_reg(REG_PAST_OUT1, c.past_out1_coef);
        write_reg(REG_PAST_OUT2, c.past_out2_coef);
        write_reg(REG_ERR0,      c.err0_coef);
        write_reg(REG_ERR1,      c.err1_coef);
        write_reg(REG_ERR2,      c.err2_coef);
        write_reg(REG_WINDUP,    c.windup_gain);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // coefficients out of reset are zero, so the drive sits at zero
    task automatic test_register_reset();
        send_item(make_item(32767, -32768));
        send_item(make_item(-32768, 32767));
        send_item(make_item(1234, -567));
        wait_idle();
    endtask

    // field extremes and alternating bit patterns through an integrator
    task automatic test_field_extremes();
        pfd_coef_t c;
        c.past_out1_coef = -65536;
        c.past_out2_coef = 0;
        c.err0_coef      = 32'sh00004000;
        c.err1_coef      = 32'sh00002000;
        c.err2_coef      = -32'sh00001000;
        c.windup_gain    = 32'sh00008000;
        load_coefs(c);
        send_item(make_item(32767, -32768));    // largest positive error
        send_item(make_item(-32768, 32767));    // largest negative error
        send_item(make_item(0, 0));
        send_item(make_item(32767, 32767));
        send_item(make_item(-32768, -32768));
        send_item(make_item(16'h5555, 16'haaaa));
        send_item(make_item(16'haaaa, 16'h5555));
        send_item(make_item(25600, 0));
        send_item(make_item(-1, 0));
        wait_idle();
    endtask

    // raw sum saturating both ways, and the overshoot of the lowest raw word
    task automatic test_raw_saturation();
        pfd_coef_t c;
        c.past_out1_coef = 0;
        c.past_out2_coef = 0;
        c.err0_coef      = 32'sh7fffffff;
        c.err1_coef      = 32'sh7fffffff;
        c.err2_coef      = 32'sh7fffffff;
        c.windup_gain    = 0;
        load_coefs(c);
        repeat (3) send_item(make_item(32767, -32768));
        repeat (3) send_item(make_item(-32768, 32767));
        wait_idle();
        // most negative coefficients against saturated history
        c.past_out1_coef = 32'sh80000000;
        c.past_out2_coef = 32'sh80000000;
        c.err0_coef      = 32'sh80000000;
        c.err1_coef      = 32'sh80000000;
        c.err2_coef      = 32'sh80000000;
        c.windup_gain    = 32'sh80000000;
        load_coefs(c);
        send_item(make_item(-32768, 32767));
        send_item(make_item(32767, -32768));
        wait_idle();
    endtask

    // writes to unmapped indexes leave the coefficients alone
    task automatic test_bad_index();
        load_coefs(random_coefs(COEF_TUNED));
        write_reg(REG_UNUSED_LO, 32'hffffffff);
        write_reg(REG_UNUSED_HI, 32'h7fffffff);
        cfg_wr_en <= 1'b0;
        send_item(make_item(6400, 0));
        send_item(make_item(12800, 3200));
        send_item(make_item(-6400, 100));
        wait_idle();
    endtask

    // three idling modes, three coefficient sets in each
    task automatic test_random_sweep();
        int plan[9] = '{COEF_TUNED, COEF_EXTREME, COEF_INTEGRATOR,
                        COEF_INTEGRATOR, COEF_RAW, COEF_TUNED,
                        COEF_TUNED, COEF_INTEGRATOR, COEF_EXTREME};
        int src_mode[3]  = '{35, 71, 0};
        int sink_mode[3] = '{71, 35, 0};
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct  = src_mode[mode];
            sink_idle_pct = sink_mode[mode];
            for (int n = 0; n < 3; n++) begin
                load_coefs(random_coefs(plan[mode * 3 + n]));
                repeat (SET_ITEMS) send_item(random_item());
                wait_idle();
            end
        end
    endtask

    // receiver holds off while the sender keeps offering, the pipe fills
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_coefs(random_coefs(COEF_INTEGRATOR));
        hold_len <= HOLD_CYCLES;
        repeat (40) send_item(random_item());
        wait_idle();
    endtask

    // bursts with the sender pausing until every result has drained
    task automatic test_drain_pause();
        src_idle_pct  = 35;
        sink_idle_pct = 71;
        load_coefs(random_coefs(COEF_TUNED));
        repeat (3) begin
            repeat (30) send_item(random_item());
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_reset();
        test_field_extremes();
        test_raw_saturation();
        test_bad_index();
        test_random_sweep();
        test_output_backpressure();
        test_drain_pause();

        // last results, then a quiet drain for any stray item
        wait_idle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pfd_pkg.sv
rtl/pfd_term.sv
rtl/pfd_core.sv
rtl/pid_filtered_derivative_antiwindup.sv
tb/sv/tb_top.sv
